// File: src/rms_pkg.sv
package rms_pkg;

    // Field widths of the input and result words.
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned COUNT_W = 6;

    // Default timebase: microsecond ticks.
    localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;

    // Reset value of the prepare delay register, in microseconds.
    localparam logic [TIME_W-1:0] PREPARE_DELAY_RST = 32'd5000000;

    // Gesture counter limits; the abort value selects no mode.
    localparam logic [COUNT_W-1:0] ABORT_COUNT = 6'd42;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 6'd63;

    // Gesture counts that select a mode.
    localparam logic [COUNT_W-1:0] GESTURE_PREPARE   = 6'd0;
    localparam logic [COUNT_W-1:0] GESTURE_CALIBRATE = 6'd1;
    localparam logic [COUNT_W-1:0] GESTURE_TEST      = 6'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_WAIT      = 3'd0,
        MODE_CALIBRATE = 3'd1,
        MODE_PREPARE   = 3'd2,
        MODE_FIGHT     = 3'd3,
        MODE_TEST      = 3'd4,
        MODE_BRAINDEAD = 3'd5
    } mode_t;

endpackage

// File: src/rms_if.sv
// Input channel: one control-loop tick per word.
interface rms_in_if;
    import rms_pkg::*;

    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  now_us;
    logic [LEVEL_W-1:0] left_level;
    logic [LEVEL_W-1:0] right_level;
    logic               start_signal;

    modport source (output valid, now_us, left_level, right_level, start_signal,
                    input ready);
    modport sink (input valid, now_us, left_level, right_level, start_signal,
                  output ready);
endinterface

// Result channel: one word of mode and commands per tick.
interface rms_out_if;
    import rms_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic              led_on;
    logic              motors_stop;
    logic              run_calibrate;
    logic              run_fight;
    logic              run_test;

    modport source (output valid, mode, led_on, motors_stop, run_calibrate,
                    run_fight, run_test, input ready);
    modport sink (input valid, mode, led_on, motors_stop, run_calibrate,
                  run_fight, run_test, output ready);
endinterface

// File: src/robot_mode_sequencer_core.sv
// A word accepted at the input is held in the input register; its result is written
// into the result register when the result slot is free (empty or being taken).
// Throughput: one word per clock unless out_ch.ready stalls; the input and the result
// registers form a two-stage pipeline and the mode update is one short step of logic.
// Reset (rst_n, asynchronous, active low) clears the mode to waiting, the sensor
// history, the counters and timestamps, the LED, and sets the prepare delay to 5 s.
module robot_mode_sequencer_core #(
    parameter int unsigned TICKS_PER_SECOND = rms_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    rms_in_if.sink                     in_ch,
    rms_out_if.source                  out_ch,
    input  logic                       cfg_wr_en,
    input  logic [rms_pkg::TIME_W-1:0] cfg_wr_data
);
    import rms_pkg::*;

    // Blink periods and on times for each group of modes.
    localparam logic [TIME_W-1:0] BD_PERIOD  = TIME_W'(TICKS_PER_SECOND * 2);
    localparam logic [TIME_W-1:0] BD_ON      = TIME_W'(TICKS_PER_SECOND);
    localparam logic [TIME_W-1:0] PREP_PERIOD = TIME_W'(TICKS_PER_SECOND / 10);
    localparam logic [TIME_W-1:0] PREP_ON     = TIME_W'(TICKS_PER_SECOND / 20);
    localparam logic [TIME_W-1:0] RUN_PERIOD  = TIME_W'((TICKS_PER_SECOND / 2) / 2);
    localparam logic [TIME_W-1:0] RUN_ON      = TIME_W'((TICKS_PER_SECOND / 3) / 5);
    localparam logic [TIME_W-1:0] IDLE_PERIOD = TIME_W'(TICKS_PER_SECOND / 2);
    localparam logic [TIME_W-1:0] IDLE_ON     = TIME_W'(TICKS_PER_SECOND / 5);

    // Configuration register.
    logic [TIME_W-1:0]  prepare_delay_reg;

    // Input register.
    logic               in_valid_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [LEVEL_W-1:0] left_reg;
    logic [LEVEL_W-1:0] right_reg;
    logic               start_reg;

    // Block state.
    mode_t              mode_reg, mode_next;
    logic [LEVEL_W-1:0] prev_left_reg;
    logic [LEVEL_W-1:0] prev_right_reg;
    logic [COUNT_W-1:0] gesture_reg, gesture_next;
    logic [TIME_W-1:0]  prepare_start_reg, prepare_start_next;
    logic [TIME_W-1:0]  blink_start_reg, blink_start_next;
    logic               led_reg, led_next;

    // Result register.
    logic               out_valid_reg;
    logic [MODE_W-1:0]  out_mode_reg;
    logic               out_led_reg;
    logic               out_stop_reg, stop_next;
    logic               out_cal_reg, cal_next;
    logic               out_fight_reg, fight_next;
    logic               out_test_reg, test_next;

    // Handshake: the result slot frees when empty or being taken.
    logic out_free;
    logic step;
    logic in_take;

    mode_t             mode_upd;
    logic              abort_stop;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] blink_elapsed;
    logic [TIME_W-1:0] prepare_elapsed;

    assign out_free     = !out_valid_reg || out_ch.ready;
    assign step         = in_valid_reg && out_free;
    assign in_ch.ready  = !in_valid_reg || out_free;
    assign in_take      = in_ch.valid && in_ch.ready;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.mode          = out_mode_reg;
    assign out_ch.led_on        = out_led_reg;
    assign out_ch.motors_stop   = out_stop_reg;
    assign out_ch.run_calibrate = out_cal_reg;
    assign out_ch.run_fight     = out_fight_reg;
    assign out_ch.run_test      = out_test_reg;

    assign prepare_elapsed = now_reg - prepare_start_reg;
    assign blink_elapsed   = now_reg - blink_start_reg;

    // Mode update from the sensors, the start bit and the prepare timer.
    always_comb
    begin
        mode_upd           = mode_reg;
        gesture_next       = gesture_reg;
        prepare_start_next = prepare_start_reg;
        abort_stop         = 1'b0;
        if (mode_reg == MODE_WAIT)
        begin
            if (start_reg)
            begin
                mode_upd = MODE_FIGHT;
            end
            else if (right_reg != '0)
            begin
                if (left_reg < prev_left_reg && gesture_reg != COUNT_MAX)
                begin
                    gesture_next = gesture_reg + 1'b1;
                end
            end
            else if (right_reg < prev_right_reg)
            begin
                if (left_reg == '0)
                begin
                    priority if (gesture_reg == GESTURE_PREPARE)
                    begin
                        mode_upd           = MODE_PREPARE;
                        prepare_start_next = now_reg;
                    end
                    else if (gesture_reg == GESTURE_CALIBRATE)
                    begin
                        mode_upd = MODE_CALIBRATE;
                    end
                    else if (gesture_reg == GESTURE_TEST)
                    begin
                        mode_upd = MODE_TEST;
                    end
                    else
                    begin
                        mode_upd = MODE_WAIT;
                    end
                end
                gesture_next = '0;
            end
        end
        else if (left_reg != '0 && right_reg != '0)
        begin
            // Both sensors covered: abort.
            if (mode_reg == MODE_FIGHT)
            begin
                mode_upd = MODE_BRAINDEAD;
            end
            else if (mode_reg != MODE_BRAINDEAD)
            begin
                mode_upd     = MODE_WAIT;
                gesture_next = ABORT_COUNT;
            end
            abort_stop = 1'b1;
        end
        else if (mode_reg == MODE_PREPARE)
        begin
            if (prepare_elapsed >= prepare_delay_reg)
            begin
                mode_upd = MODE_FIGHT;
            end
        end
    end

    // Blink pattern chosen by the updated mode.
    always_comb
    begin
        unique case (mode_upd)
            MODE_BRAINDEAD:
            begin
                period  = BD_PERIOD;
                on_time = BD_ON;
            end
            MODE_PREPARE:
            begin
                period  = PREP_PERIOD;
                on_time = PREP_ON;
            end
            MODE_FIGHT, MODE_TEST:
            begin
                period  = RUN_PERIOD;
                on_time = RUN_ON;
            end
            default:
            begin
                period  = IDLE_PERIOD;
                on_time = IDLE_ON;
            end
        endcase
    end

    // LED level, then the action for the mode.
    always_comb
    begin
        led_next         = led_reg;
        blink_start_next = blink_start_reg;
        mode_next        = mode_upd;
        stop_next        = abort_stop;
        cal_next         = 1'b0;
        fight_next       = 1'b0;
        test_next        = 1'b0;
        if (blink_elapsed >= period)
        begin
            led_next         = 1'b1;
            blink_start_next = now_reg;
        end
        else if (blink_elapsed >= on_time)
        begin
            led_next = 1'b0;
        end
        unique case (mode_upd)
            MODE_BRAINDEAD, MODE_PREPARE:
            begin
                stop_next = 1'b1;
            end
            MODE_CALIBRATE:
            begin
                // Calibration lasts a single tick.
                cal_next  = 1'b1;
                led_next  = 1'b1;
                mode_next = MODE_WAIT;
            end
            MODE_FIGHT:
            begin
                fight_next = 1'b1;
            end
            MODE_TEST:
            begin
                test_next = 1'b1;
            end
            default:
            begin
                mode_next = mode_upd;
            end
        endcase
        if (mode_upd == MODE_CALIBRATE)
        begin
            stop_next = 1'b1;
        end
    end

    // Prepare delay register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prepare_delay_reg <= PREPARE_DELAY_RST;
        end
        else if (cfg_wr_en)
        begin
            prepare_delay_reg <= cfg_wr_data;
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg   <= in_ch.now_us;
            left_reg  <= in_ch.left_level;
            right_reg <= in_ch.right_level;
            start_reg <= in_ch.start_signal;
        end
    end

    // Block state, advanced once per word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_WAIT;
            prev_left_reg     <= '0;
            prev_right_reg    <= '0;
            gesture_reg       <= '0;
            prepare_start_reg <= '0;
            blink_start_reg   <= '0;
            led_reg           <= 1'b0;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            prev_left_reg     <= left_reg;
            prev_right_reg    <= right_reg;
            gesture_reg       <= gesture_next;
            prepare_start_reg <= prepare_start_next;
            blink_start_reg   <= blink_start_next;
            led_reg           <= led_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_mode_reg  <= mode_next;
            out_led_reg   <= led_next;
            out_stop_reg  <= stop_next;
            out_cal_reg   <= cal_next;
            out_fight_reg <= fight_next;
            out_test_reg  <= test_next;
        end
    end

`ifndef ASSERT_OFF
    // Calibrate never outlives its own tick.
    a_no_held_calibrate: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_CALIBRATE)
        else $error("calibrate mode held in state");

    // A calibrate word reports waiting, LED on and motors stopped.
    a_cal_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_cal_reg |->
            out_mode_reg == MODE_WAIT && out_led_reg && out_stop_reg)
        else $error("calibrate word malformed");

    // Abort from prepare or test returns to waiting with the abort count.
    a_abort: assert property (@(posedge clk) disable iff (!rst_n)
        step && (mode_reg == MODE_PREPARE || mode_reg == MODE_TEST)
            && left_reg != '0 && right_reg != '0 |=>
            mode_reg == MODE_WAIT && gesture_reg == ABORT_COUNT)
        else $error("abort did not return to waiting");

    // Running behaviours never coincide with stopped motors.
    a_run_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !((out_fight_reg || out_test_reg) && out_stop_reg)
            && !(out_fight_reg && out_test_reg))
        else $error("conflicting action in result word");
`endif

endmodule

// File: test/robot_mode_sequencer_core_tb.sv
module robot_mode_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rms_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_TICKS = 190;

    // Blink timing, worked out the same way as the block does it.
    localparam int unsigned TPS = TICKS_PER_SECOND_DEF;
    localparam logic [TIME_W-1:0] BD_PERIOD    = 2 * TPS;
    localparam logic [TIME_W-1:0] BD_ON        = TPS;
    localparam logic [TIME_W-1:0] PREP_PERIOD  = TPS / 10;
    localparam logic [TIME_W-1:0] PREP_ON      = TPS / 20;
    localparam logic [TIME_W-1:0] FIGHT_PERIOD = (TPS / 2) / 2;
    localparam logic [TIME_W-1:0] FIGHT_ON     = (TPS / 3) / 5;
    localparam logic [TIME_W-1:0] IDLE_PERIOD  = TPS / 2;
    localparam logic [TIME_W-1:0] IDLE_ON      = TPS / 5;

    typedef struct packed {
        logic [TIME_W-1:0]  now;
        logic [LEVEL_W-1:0] left;
        logic [LEVEL_W-1:0] right;
        logic               start;
    } tick_t;

    typedef struct packed {
        mode_t mode;
        logic  led;
        logic  stop;
        logic  cal;
        logic  fight;
        logic  test;
    } outcome_t;

    typedef struct {
        tick_t    stim;
        bit       typed;
        outcome_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [TIME_W-1:0] cfg_wr_data = '0;

    rms_in_if  in_ch ();
    rms_out_if out_ch ();

    robot_mode_sequencer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow of the sequencer state, starting from its reset values.
    mode_t              model_mode  = MODE_WAIT;
    logic [LEVEL_W-1:0] seen_left   = '0;
    logic [LEVEL_W-1:0] seen_right  = '0;
    logic [COUNT_W-1:0] gesture_cnt = '0;
    logic [TIME_W-1:0]  prepare_t0  = '0;
    logic [TIME_W-1:0]  blink_t0    = '0;
    logic               led_lvl     = 1'b0;
    logic [TIME_W-1:0]  delay_reg   = PREPARE_DELAY_RST;

    outcome_t          pending_outcomes [$];
    outcome_t          oldest;
    int                errors     = 0;
    int                ticks_sent = 0;
    int                cycle_cnt  = 0;
    int                stall_left = 0;
    int                gap_odds   = 0;
    bit                stalls_on  = 1'b0;
    bit                calm       = 1'b0;
    logic [TIME_W-1:0] last_now   = '0;

    // Directed words: typed expectations only where the answer is obvious.
    dir_row_t directed_rows [0:22] = '{
        // Quiet ticks after reset walk the LED through one blink.
        '{'{32'd0, 8'd0, 8'd0, 1'b0}, 1'b1, '{MODE_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{32'd500000, 8'd0, 8'd0, 1'b0}, 1'b1, '{MODE_WAIT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{32'd700000, 8'd0, 8'd0, 1'b0}, 1'b1, '{MODE_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        // One gesture pulse, then the right sensor clears: calibrate for one tick.
        '{'{32'd700001, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
        '{'{32'd700002, 8'd0, 8'd255, 1'b0}, 1'b0, '0},
        '{'{32'd700003, 8'd0, 8'd0, 1'b0}, 1'b1, '{MODE_WAIT, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
        // Two pulses select test mode; start is ignored there.
        '{'{32'd710000, 8'd200, 8'd1, 1'b0}, 1'b0, '0},
        '{'{32'd720000, 8'd100, 8'd1, 1'b0}, 1'b0, '0},
        '{'{32'd730000, 8'd0, 8'd1, 1'b0}, 1'b0, '0},
        '{'{32'd740000, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
        '{'{32'd750000, 8'd0, 8'd0, 1'b1}, 1'b0, '0},
        '{'{32'd760000, 8'd255, 8'd0, 1'b0}, 1'b0, '0},
        // Both sensors abort test mode; the abort count then selects nothing.
        '{'{32'd770000, 8'd1, 8'd1, 1'b0}, 1'b0, '0},
        '{'{32'd780000, 8'd0, 8'd7, 1'b0}, 1'b0, '0},
        '{'{32'd790000, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
        // Right sensor falls with the left one active: count cleared, no mode.
        '{'{32'd800000, 8'd0, 8'd9, 1'b0}, 1'b0, '0},
        '{'{32'd810000, 8'd3, 8'd0, 1'b0}, 1'b0, '0},
        // No pulses select prepare; abort wins over a timeout in the same tick.
        '{'{32'd820000, 8'd3, 8'd9, 1'b0}, 1'b0, '0},
        '{'{32'd830000, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
        '{'{32'd5829999, 8'd0, 8'd200, 1'b1}, 1'b0, '0},
        '{'{32'd5830000, 8'd128, 8'd128, 1'b0}, 1'b0, '0},
        // Timestamp at its top value and just past the wrap.
        '{'{32'hFFFF_FFFF, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
        '{'{32'd5, 8'd0, 8'd0, 1'b0}, 1'b0, '0}
    };

    // One control-loop tick of the mode machine, blink pattern and action.
    function automatic outcome_t mode_step(input tick_t t);
        outcome_t          o;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] since;
        o = '0;
        if (model_mode == MODE_WAIT) begin
            if (t.start) begin
                model_mode = MODE_FIGHT;
            end
            else if (t.right != 0) begin
                if (t.left < seen_left && gesture_cnt < COUNT_MAX)
                    gesture_cnt = gesture_cnt + 1'b1;
            end
            else if (t.right < seen_right) begin
                if (t.left == 0) begin
                    if (gesture_cnt == GESTURE_PREPARE) begin
                        model_mode = MODE_PREPARE;
                        prepare_t0 = t.now;
                    end
                    else if (gesture_cnt == GESTURE_CALIBRATE) begin
                        model_mode = MODE_CALIBRATE;
                    end
                    else if (gesture_cnt == GESTURE_TEST) begin
                        model_mode = MODE_TEST;
                    end
                end
                gesture_cnt = '0;
            end
        end
        else if (t.left != 0 && t.right != 0) begin
            if (model_mode == MODE_FIGHT) begin
                model_mode = MODE_BRAINDEAD;
            end
            else if (model_mode != MODE_BRAINDEAD) begin
                model_mode  = MODE_WAIT;
                gesture_cnt = ABORT_COUNT;
            end
            o.stop = 1'b1;
        end
        else if (model_mode == MODE_PREPARE) begin
            since = t.now - prepare_t0;
            if (since >= delay_reg)
                model_mode = MODE_FIGHT;
        end
        seen_left  = t.left;
        seen_right = t.right;

        case (model_mode)
            MODE_BRAINDEAD:
            begin
                period  = BD_PERIOD;
                on_time = BD_ON;
            end
            MODE_PREPARE:
            begin
                period  = PREP_PERIOD;
                on_time = PREP_ON;
            end
            MODE_FIGHT, MODE_TEST:
            begin
                period  = FIGHT_PERIOD;
                on_time = FIGHT_ON;
            end
            default:
            begin
                period  = IDLE_PERIOD;
                on_time = IDLE_ON;
            end
        endcase
        since = t.now - blink_t0;
        if (since >= period) begin
            led_lvl  = 1'b1;
            blink_t0 = t.now;
        end
        else if (since >= on_time) begin
            led_lvl = 1'b0;
        end

        case (model_mode)
            MODE_BRAINDEAD, MODE_PREPARE: o.stop = 1'b1;
            MODE_CALIBRATE:
            begin
                o.stop     = 1'b1;
                o.cal      = 1'b1;
                led_lvl    = 1'b1;
                model_mode = MODE_WAIT;
            end
            MODE_FIGHT: o.fight = 1'b1;
            MODE_TEST: o.test = 1'b1;
            default: ;
        endcase
        o.mode = model_mode;
        o.led  = led_lvl;
        return o;
    endfunction

    // Mostly short steps in time, now and then long ones or a jump anywhere.
    function automatic logic [TIME_W-1:0] next_now();
        int unsigned pick;
        pick = $urandom_range(0, 63);
        if (pick == 0)
            return $urandom;
        else if (pick < 5)
            return last_now + $urandom_range(80000, 3000000);
        return last_now + $urandom_range(0, 80000);
    endfunction

    // A nonzero sensor level, biased towards the ends of the range.
    function automatic logic [LEVEL_W-1:0] any_level();
        case ($urandom_range(0, 7))
            0: return 8'd1;
            1: return 8'd255;
            default: return LEVEL_W'($urandom_range(1, 255));
        endcase
    endfunction

    // Offer one word, wait for it to be taken, then queue its outcome.
    task automatic send_tick(input tick_t t, input bit typed = 1'b0, input outcome_t want = '0);
        outcome_t predicted;
        if (gap_odds != 0 && !calm && $urandom_range(1, gap_odds) == 1) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.now_us       <= t.now;
        in_ch.left_level   <= t.left;
        in_ch.right_level  <= t.right;
        in_ch.start_signal <= t.start;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predicted = mode_step(t);
        pending_outcomes.push_back(typed ? want : predicted);
        last_now   = t.now;
        ticks_sent = ticks_sent + 1;
    endtask

    // Stop offering words and let every outstanding result come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_prepare_delay(input logic [TIME_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        delay_reg = value;
    endtask

    // Bring the gesture count and the left history back to zero without
    // selecting a mode: the right sensor falls while the left one is active.
    task automatic clear_gestures();
        if (gesture_cnt != 0 || seen_left != 0) begin
            send_tick(tick_t'{next_now(), 8'd0, any_level(), 1'b0});
            send_tick(tick_t'{next_now(), any_level(), 8'd0, 1'b0});
            send_tick(tick_t'{next_now(), 8'd0, 8'd0, 1'b0});
        end
    endtask

    // Right sensor held while the left one falls once per pulse, then the
    // right sensor clears; a clean ending has the left sensor clear as well.
    task automatic gesture_run(input int pulses, input bit clean);
        logic [LEVEL_W-1:0] hi;
        send_tick(tick_t'{next_now(), 8'd0, any_level(), 1'b0});
        for (int i = 0; i < pulses; i++) begin
            hi = any_level();
            send_tick(tick_t'{next_now(), hi, any_level(), 1'b0});
            send_tick(tick_t'{next_now(), LEVEL_W'($urandom_range(0, int'(hi) - 1)),
                              any_level(), 1'b0});
        end
        send_tick(tick_t'{next_now(), clean ? 8'd0 : any_level(), 8'd0, 1'b0});
    endtask

    // Ticks inside test or prepare mode, ended by an abort. Prepare is aborted
    // before it can time out, since fight mode can only be left for braindead mode.
    task automatic roam_mode();
        int                 n;
        int unsigned        side;
        logic [TIME_W-1:0]  now;
        logic [TIME_W-1:0]  since;
        logic [LEVEL_W-1:0] l;
        logic [LEVEL_W-1:0] r;
        logic               s;
        n = $urandom_range(0, 12);
        while (n > 0 && model_mode != MODE_WAIT) begin
            now   = next_now();
            since = now - prepare_t0;
            if (model_mode == MODE_PREPARE && since >= delay_reg) begin
                n = 0;
            end
            else begin
                side = $urandom_range(0, 2);
                l    = (side == 0) ? any_level() : 8'd0;
                r    = (side == 1) ? any_level() : 8'd0;
                s    = 1'($urandom_range(0, 1));
                send_tick(tick_t'{now, l, r, s});
                n = n - 1;
            end
        end
        if (model_mode != MODE_WAIT) begin
            s = 1'($urandom_range(0, 1));
            send_tick(tick_t'{next_now(), any_level(), any_level(), s});
        end
    endtask

    // Result side: check each accepted word, then stall in random bursts.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors = errors + 1;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual mode %0d",
                         $time, out_ch.mode);
                errors = errors + 1;
            end
            else begin
                oldest = pending_outcomes.pop_front();
                check_field("mode", 32'(oldest.mode), 32'(out_ch.mode));
                check_field("led_on", 32'(oldest.led), 32'(out_ch.led_on));
                check_field("motors_stop", 32'(oldest.stop), 32'(out_ch.motors_stop));
                check_field("run_calibrate", 32'(oldest.cal), 32'(out_ch.run_calibrate));
                check_field("run_fight", 32'(oldest.fight), 32'(out_ch.run_fight));
                check_field("run_test", 32'(oldest.test), 32'(out_ch.run_test));
            end
        end
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (stalls_on && !calm && $urandom_range(0, 9) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 12);
        end
        else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("robot_mode_sequencer_core test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned        pick;
        int                 pulses;
        int                 noise_left;
        logic [TIME_W-1:0]  delay_pick;
        logic [LEVEL_W-1:0] nl;
        logic [LEVEL_W-1:0] nr;
        logic               s;
        int unsigned        side;

        in_ch.valid        <= 1'b0;
        in_ch.now_us       <= '0;
        in_ch.left_level   <= '0;
        in_ch.right_level  <= '0;
        in_ch.start_signal <= 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words with the reset prepare delay.
        gap_odds  = 5;
        stalls_on = 1'b1;
        for (int i = 0; i < $size(directed_rows); i++)
            send_tick(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

        // Random phases, each under its own prepare delay and idling pattern.
        for (int p = 0; p < 6; p++) begin
            if (model_mode != MODE_WAIT)
                roam_mode();
            case (p)
                0: delay_pick = '0;
                1: delay_pick = 32'd1;
                2: delay_pick = 32'hFFFF_FFFF;
                3: delay_pick = FIGHT_ON;
                4: delay_pick = $urandom_range(0, 400000);
                default: delay_pick = PREPARE_DELAY_RST;
            endcase
            set_prepare_delay(delay_pick);
            gap_odds  = (p == 1 || p == 4) ? 0 : 5;
            stalls_on = !(p == 2 || p == 4);
            last_now  = (p == 2) ? 32'hFFF0_0000 : TIME_W'($urandom);

            while (ticks_sent < $size(directed_rows) + (p + 1) * PHASE_TICKS) begin
                pick = $urandom_range(0, 9);
                if (model_mode != MODE_WAIT) begin
                    roam_mode();
                end
                else if (pick < 7) begin
                    clear_gestures();
                    pick = $urandom_range(0, 99);
                    if (pick < 30)
                        pulses = 0;
                    else if (pick < 55)
                        pulses = 1;
                    else if (pick < 80)
                        pulses = 2;
                    else if (pick < 90)
                        pulses = $urandom_range(3, 5);
                    else if (pick < 96)
                        pulses = $urandom_range(6, 20);
                    else
                        pulses = $urandom_range(60, 70);
                    gesture_run(pulses, $urandom_range(0, 7) != 0);
                end
                else begin
                    // Stray sensor readings while waiting.
                    noise_left = $urandom_range(1, 4);
                    while (noise_left > 0 && model_mode == MODE_WAIT) begin
                        nl = ($urandom_range(0, 1) != 0) ? any_level() : 8'd0;
                        nr = ($urandom_range(0, 1) != 0) ? any_level() : 8'd0;
                        send_tick(tick_t'{next_now(), nl, nr, 1'b0});
                        noise_left = noise_left - 1;
                    end
                end
            end
        end

        // Closing stretch without idling: into fight mode, then braindead.
        if (model_mode != MODE_WAIT)
            roam_mode();
        set_prepare_delay(32'hFFFF_FFFF);
        calm = 1'b1;
        clear_gestures();
        if ($urandom_range(0, 1) != 0) begin
            send_tick(tick_t'{next_now(), 8'd0, 8'd0, 1'b1});
        end
        else begin
            // Prepare times out only when the elapsed time is the full delay.
            gesture_run(0, 1'b1);
            repeat (2) send_tick(tick_t'{last_now + $urandom_range(0, 80000), 8'd0, 8'd0, 1'b0});
            send_tick(tick_t'{prepare_t0 - 1, 8'd0, 8'd0, 1'b0});
        end
        repeat (40) begin
            side = $urandom_range(0, 2);
            nl   = (side == 0) ? any_level() : 8'd0;
            nr   = (side == 1) ? any_level() : 8'd0;
            s    = 1'($urandom_range(0, 1));
            send_tick(tick_t'{next_now(), nl, nr, s});
        end
        send_tick(tick_t'{next_now(), any_level(), any_level(), 1'b0});
        repeat (40) begin
            nl = ($urandom_range(0, 1) != 0) ? any_level() : 8'd0;
            nr = ($urandom_range(0, 1) != 0) ? any_level() : 8'd0;
            s  = 1'($urandom_range(0, 1));
            send_tick(tick_t'{next_now(), nl, nr, s});
        end

        drain_results();
        if (errors == 0)
            $display("robot_mode_sequencer_core test passed");
        else
            $display("robot_mode_sequencer_core test failed");
        $finish;
    end

endmodule
